// ===== sv/tdcf_pkg.sv =====
// Shared types and constants for the table-driven connection sequencer.
// No dependencies; imported by tdcf_table and table_driven_connection_fsm_core.
package tdcf_pkg;

    // Connection state codes
    localparam logic [3:0] ST_DISCONNECTED = 4'd0;
    localparam logic [3:0] ST_MQTT_OK      = 4'd5;
    localparam logic [3:0] ST_RECONNECT    = 4'd10;
    localparam logic [3:0] ST_TIMEOUT      = 4'd11;
    localparam logic [3:0] ST_HIBERNATE    = 4'd12;

    // Event codes with fixed handling
    localparam logic [4:0] EV_DISCONNECTED = 5'd3;
    localparam logic [4:0] EV_RETRY        = 5'd10;
    localparam logic [4:0] EV_SYSTEM_FAULT = 5'd16;
    localparam logic [4:0] EV_BROKER_DOWN  = 5'd17;

    // Register map
    localparam logic [2:0] REG_RETRY_LIMIT = 3'd0;
    localparam logic [2:0] REG_TABLE_FIRST = 3'd1;

    localparam int TABLE_WORDS      = 7;
    localparam int ENTRIES_PER_WORD = 4;
    localparam int ENTRY_BITS       = 14;
    localparam int WORD_BITS        = TABLE_WORDS * 0 + ENTRIES_PER_WORD * ENTRY_BITS;
    localparam int NUM_ENTRIES      = TABLE_WORDS * ENTRIES_PER_WORD;
    localparam int ENTRY_IDX_BITS   = $clog2(NUM_ENTRIES);
    localparam logic [ENTRY_IDX_BITS-1:0] LAST_ENTRY = ENTRY_IDX_BITS'(NUM_ENTRIES - 1);

    typedef logic [ENTRY_IDX_BITS-1:0] entry_idx_t;
    typedef logic [WORD_BITS-1:0]      table_word_t;

    // One transition entry, bit 13 down to bit 0
    typedef struct packed {
        logic       valid;
        logic [3:0] cur_state;
        logic [4:0] evt;
        logic [3:0] nxt_state;
    } entry_t;

    // Configuration write towards the table
    typedef struct packed {
        logic        en;
        logic [2:0]  index;
        table_word_t data;
    } cfg_wr_t;

endpackage

// ===== sv/tdcf_table.sv =====
// Configuration registers: retry limit and the seven packed transition-table words.
// Depends on tdcf_pkg; one entry read port addressed by the scan index.
module tdcf_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  tdcf_pkg::cfg_wr_t   cfg_wr,
    input  tdcf_pkg::entry_idx_t rd_idx,
    output tdcf_pkg::entry_t    rd_entry,
    output logic [7:0]          retry_limit
);
    import tdcf_pkg::*;

    table_word_t words_reg [TABLE_WORDS];
    logic [7:0]  retry_limit_reg;
    table_word_t rd_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= 8'd3;
            for (int w = 0; w < TABLE_WORDS; w++) begin
                words_reg[w] <= '0;
            end
        end else if (cfg_wr.en) begin
            if (cfg_wr.index == REG_RETRY_LIMIT) begin
                retry_limit_reg <= cfg_wr.data[7:0];
            end else begin
                words_reg[3'(cfg_wr.index - REG_TABLE_FIRST)] <= cfg_wr.data;
            end
        end
    end

    // word select, then lane select within the word
    assign rd_word = words_reg[rd_idx[ENTRY_IDX_BITS-1:2]];

    always_comb begin
        case (rd_idx[1:0])
            2'd0:    rd_entry = entry_t'(rd_word[0*ENTRY_BITS +: ENTRY_BITS]);
            2'd1:    rd_entry = entry_t'(rd_word[1*ENTRY_BITS +: ENTRY_BITS]);
            2'd2:    rd_entry = entry_t'(rd_word[2*ENTRY_BITS +: ENTRY_BITS]);
            default: rd_entry = entry_t'(rd_word[3*ENTRY_BITS +: ENTRY_BITS]);
        endcase
    end

    assign retry_limit = retry_limit_reg;

endmodule

// ===== sv/table_driven_connection_fsm_core.sv =====
// Top level of the table-driven connection sequencer: event sequencer and result register.
// Depends on tdcf_pkg and tdcf_table.
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  input    | s_valid, s_ready, s_event_code                | in
//  result   | m_valid, m_ready, m_conn_state, m_retry_total,| out
//           | m_rule_matched, m_state_written               |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data     | in
//
// Forced events (fault, broker down, retry at the limit) go from idle straight to the
// done state; other events step the single entry comparator over the 28 table
// entries, stopping at the first match or after the last entry, and the result then
// waits in the done state for m_ready.
// Synchronous active-low reset: state disconnected, counter zero, limit 3, table empty.
// s_ready is high only when idle; cfg_ready is always high.
module table_driven_connection_fsm_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [4:0]             s_event_code,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_conn_state,
    output logic [7:0]             m_retry_total,
    output logic                   m_rule_matched,
    output logic                   m_state_written,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  tdcf_pkg::table_word_t  cfg_data
);
    import tdcf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } seq_state_t;

    seq_state_t seq_reg, seq_next;
    logic [3:0] mode_reg, mode_next;        // current connection state
    logic [7:0] retries_reg, retries_next;  // retry counter
    logic       matched_reg, matched_next;
    logic       written_reg, written_next;
    logic [4:0] evt_reg, evt_next;          // event under processing
    entry_idx_t idx_reg, idx_next;          // scan position

    cfg_wr_t    cfg_wr;
    entry_t     entry;
    logic [7:0] retry_limit;
    logic       hit;

    // Configuration is accepted in every cycle
    assign cfg_ready    = 1'b1;
    assign cfg_wr.en    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    tdcf_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr      (cfg_wr),
        .rd_idx      (idx_reg),
        .rd_entry    (entry),
        .retry_limit (retry_limit)
    );

    // The shared comparator: one entry against current state and event
    assign hit = entry.valid && (entry.cur_state == mode_reg) && (entry.evt == evt_reg);

    always_comb begin
        seq_next     = seq_reg;
        mode_next    = mode_reg;
        retries_next = retries_reg;
        matched_next = matched_reg;
        written_next = written_reg;
        evt_next     = evt_reg;
        idx_next     = idx_reg;

        unique case (seq_reg)
            S_IDLE: begin
                if (s_valid) begin
                    evt_next     = s_event_code;
                    idx_next     = '0;
                    matched_next = 1'b0;
                    written_next = 1'b0;
                    // fixed events take priority over the table
                    if (s_event_code == EV_SYSTEM_FAULT) begin
                        mode_next    = ST_HIBERNATE;
                        written_next = 1'b1;
                        seq_next     = S_DONE;
                    end else if (s_event_code == EV_BROKER_DOWN) begin
                        mode_next    = ST_DISCONNECTED;
                        written_next = 1'b1;
                        seq_next     = S_DONE;
                    end else if (s_event_code == EV_RETRY && retries_reg >= retry_limit) begin
                        mode_next    = ST_TIMEOUT;
                        written_next = 1'b1;
                        seq_next     = S_DONE;
                    end else begin
                        // retry below the limit moves to reconnect, then looks up
                        if (s_event_code == EV_RETRY) begin
                            retries_next = retries_reg + 8'd1;
                            mode_next    = ST_RECONNECT;
                            written_next = 1'b1;
                        end
                        seq_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // a disconnect clears the counter except out of reconnect
                    if (evt_reg == EV_DISCONNECTED && mode_reg != ST_RECONNECT) begin
                        retries_next = '0;
                    end
                    mode_next    = entry.nxt_state;
                    matched_next = 1'b1;
                    written_next = 1'b1;
                    seq_next     = S_DONE;
                end else if (idx_reg == LAST_ENTRY) begin
                    seq_next = S_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (m_ready) begin
                    seq_next = S_IDLE;
                end
            end
            default: begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= S_IDLE;
            mode_reg    <= ST_DISCONNECTED;
            retries_reg <= '0;
            matched_reg <= 1'b0;
            written_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            mode_reg    <= mode_next;
            retries_reg <= retries_next;
            matched_reg <= matched_next;
            written_reg <= written_next;
        end
        evt_reg <= evt_next;
        idx_reg <= idx_next;
    end

    // Result fields come straight from the state registers; they hold while S_DONE waits
    assign s_ready         = (seq_reg == S_IDLE);
    assign m_valid         = (seq_reg == S_DONE);
    assign m_conn_state    = mode_reg;
    assign m_retry_total   = retries_reg;
    assign m_rule_matched  = matched_reg;
    assign m_state_written = written_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for table_driven_connection_fsm_core: directed and random event traffic.
// Depends on tdcf_pkg and the core RTL; carries its own behavioural model of the sequencer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdcf_pkg::*;

    // Run shape
    localparam int CYCLE_LIMIT   = 600_000;  // slowest legal run stays well under this limit
    localparam int SETTLE_CYCLES = 40;       // outlasts the worst-case scan over all table entries
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRINT_CAP     = 40;

    // One result transaction as the core reports it
    typedef struct packed {
        logic [3:0] conn_state;
        logic [7:0] retry_total;
        logic       rule_matched;
        logic       state_written;
    } conn_result_t;

    // One register write on the configuration channel
    typedef struct packed {
        logic [2:0]  idx;
        table_word_t data;
    } reg_write_t;

    // Clock, reset and DUT ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [4:0]  s_event_code;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_conn_state;
    logic [7:0]  m_retry_total;
    logic        m_rule_matched;
    logic        m_state_written;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    table_word_t cfg_data;

    // Model copy of the core's registers and state
    logic [7:0]  mdl_limit;
    table_word_t mdl_words [TABLE_WORDS];
    logic [3:0]  mdl_mode;
    logic [7:0]  mdl_retries;

    // Staged configuration, committed by commit_config
    logic [7:0]  lim_img;
    table_word_t tbl_img [TABLE_WORDS];

    conn_result_t expected_results [$];
    int errors   = 0;
    int cycles   = 0;
    int idle_pct = 0;   // percent chance of a stall burst: per event sent, and per cycle on m_ready

    always #5 aclk = ~aclk;

    table_driven_connection_fsm_core u_top (.*);

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Entry k of the model's table; entry 4w+j sits in word w at bit 14j.
    function automatic entry_t entry_of(input int k);
        return entry_t'(mdl_words[k / ENTRIES_PER_WORD]
                                 [(k % ENTRIES_PER_WORD) * ENTRY_BITS +: ENTRY_BITS]);
    endfunction

    // Advance the model by one event and return what the core should report.
    // Fixed events take priority; a RETRY below the limit bumps the counter,
    // parks in reconnect and still goes on to the first-match table scan.
    function automatic conn_result_t next_connection(input logic [4:0] ev);
        conn_result_t r;
        entry_t       e;
        int           k;
        r = '0;
        if (ev == EV_SYSTEM_FAULT) begin
            mdl_mode        = ST_HIBERNATE;
            r.state_written = 1'b1;
        end else if (ev == EV_BROKER_DOWN) begin
            mdl_mode        = ST_DISCONNECTED;
            r.state_written = 1'b1;
        end else if (ev == EV_RETRY && mdl_retries >= mdl_limit) begin
            mdl_mode        = ST_TIMEOUT;
            r.state_written = 1'b1;
        end else begin
            if (ev == EV_RETRY) begin
                mdl_retries     = mdl_retries + 8'd1;
                mdl_mode        = ST_RECONNECT;
                r.state_written = 1'b1;
            end
            for (k = 0; k < NUM_ENTRIES && !r.rule_matched; k++) begin
                e = entry_of(k);
                if (e.valid && e.cur_state == mdl_mode && e.evt == ev) begin
                    // the counter survives a disconnect only out of reconnect
                    if (ev == EV_DISCONNECTED && mdl_mode != ST_RECONNECT)
                        mdl_retries = 8'd0;
                    mdl_mode        = e.nxt_state;
                    r.rule_matched  = 1'b1;
                    r.state_written = 1'b1;
                end
            end
        end
        r.conn_state  = mdl_mode;
        r.retry_total = mdl_retries;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Events that some valid entry accepts in the present state, so random
    // runs walk deep through the programmed graph, mixed with RETRY at
    // retry_bias percent, other fixed-handling events and noise over the whole 5-bit field.
    function automatic logic [4:0] pick_event(input int retry_bias);
        logic [4:0] cand [$];
        entry_t     e;
        int         k;
        int         roll;
        roll = $urandom_range(0, 99);
        for (k = 0; k < NUM_ENTRIES; k++) begin
            e = entry_of(k);
            if (e.valid && e.cur_state == mdl_mode)
                cand.push_back(e.evt);
        end
        if (roll < retry_bias)
            return EV_RETRY;
        if (roll < 58 && cand.size() != 0)
            return cand[$urandom_range(0, cand.size() - 1)];
        if (roll < 63)
            return EV_DISCONNECTED;
        if (roll < 67)
            return EV_SYSTEM_FAULT;
        if (roll < 71)
            return EV_BROKER_DOWN;
        return 5'($urandom_range(0, 31));
    endfunction

    // A random table word: now and then all zeros or all ones, otherwise
    // four entries biased towards the named states and the low events.
    function automatic table_word_t random_word();
        table_word_t w;
        entry_t      e;
        int          j;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: ;
        endcase
        for (j = 0; j < ENTRIES_PER_WORD; j++) begin
            e.valid     = ($urandom_range(0, 9) != 0);
            e.cur_state = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, 12));
            e.evt       = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(0, 12));
            e.nxt_state = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, 12));
            w[j * ENTRY_BITS +: ENTRY_BITS] = e;
        end
        return w;
    endfunction

    // Write the staged configuration in shuffled order; with write_all clear
    // a random subset is written. Only called while the core is idle.
    task automatic commit_config(input bit write_all);
        reg_write_t writes [$];
        reg_write_t wr;
        int         i;
        int         j;
        // junk above bit 7 of the limit write must be ignored
        wr.idx       = REG_RETRY_LIMIT;
        wr.data      = table_word_t'({$urandom, $urandom});
        wr.data[7:0] = lim_img;
        writes.push_back(wr);
        for (i = 0; i < TABLE_WORDS; i++) begin
            wr.idx  = 3'(REG_TABLE_FIRST + i);
            wr.data = tbl_img[i];
            writes.push_back(wr);
        end
        for (i = writes.size() - 1; i > 0; i--) begin
            j         = $urandom_range(0, i);
            wr        = writes[i];
            writes[i] = writes[j];
            writes[j] = wr;
        end
        for (i = 0; i < writes.size(); i++) begin
            if (!write_all && $urandom_range(0, 1) == 0)
                continue;
            cfg_valid <= 1'b1;
            cfg_index <= writes[i].idx;
            cfg_data  <= writes[i].data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (writes[i].idx == REG_RETRY_LIMIT)
                mdl_limit = writes[i].data[7:0];
            else
                mdl_words[writes[i].idx - REG_TABLE_FIRST] = writes[i].data;
        end
        cfg_valid <= 1'b0;
        // registers skipped above keep their old value
        lim_img = mdl_limit;
        tbl_img = mdl_words;
    endtask

    // Offer one event transaction and log its expected result on acceptance.
    // s_valid is left high so back-to-back transactions need no extra edge;
    // it only drops at the start of an idle burst or in wait_idle.
    task automatic send_event(input logic [4:0] ev);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid      <= 1'b0;
            s_event_code <= 5'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_event_code <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(next_connection(ev));
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults with an empty table: limit 3, so the fourth RETRY
    // times out; extremes of the event field fall through unmatched.
    task automatic test_fixed_events();
        logic [4:0] seq [$];
        seq = '{5'd0, 5'd31, EV_RETRY, EV_RETRY, EV_RETRY, EV_RETRY,
                EV_SYSTEM_FAULT, EV_BROKER_DOWN};
        foreach (seq[i]) send_event(seq[i]);
        wait_idle();
    endtask

    // Hand-built table: invalid entry skipped, earlier entry shadowing a
    // later one, last slot in use, unnamed state codes, RETRY carrying on
    // into the scan, disconnect clearing or keeping the counter, then a
    // limit lowered beneath the counter.
    task automatic test_table_rules();
        logic [4:0] seq [$];
        entry_t     e;
        int         k;
        int         slot [$];
        logic [13:0] ent [$];
        foreach (tbl_img[w]) tbl_img[w] = '0;
        lim_img = 8'd3;
        ent  = '{{1'b1, ST_DISCONNECTED, 5'd2,           ST_MQTT_OK},
                 {1'b0, ST_MQTT_OK,      EV_DISCONNECTED, 4'd13},
                 {1'b1, ST_MQTT_OK,      EV_DISCONNECTED, ST_DISCONNECTED},
                 {1'b1, ST_MQTT_OK,      EV_DISCONNECTED, 4'd1},
                 {1'b1, ST_DISCONNECTED, 5'd0,            4'd15},
                 {1'b1, 4'd15,           5'd31,           4'd13},
                 {1'b1, ST_RECONNECT,    EV_RETRY,        ST_RECONNECT},
                 {1'b1, ST_RECONNECT,    EV_DISCONNECTED, ST_DISCONNECTED},
                 {1'b1, 4'd13,           5'd0,            ST_DISCONNECTED}};
        slot = '{0, 1, 2, 3, 4, 5, 6, 7, NUM_ENTRIES - 1};
        foreach (ent[i]) begin
            e = entry_t'(ent[i]);
            k = slot[i];
            tbl_img[k / ENTRIES_PER_WORD][(k % ENTRIES_PER_WORD) * ENTRY_BITS +: ENTRY_BITS] = e;
        end
        commit_config(1'b1);
        seq = '{EV_BROKER_DOWN, 5'd2, EV_DISCONNECTED, 5'd0, 5'd31, 5'd0,
                EV_RETRY, EV_DISCONNECTED, EV_RETRY, EV_RETRY, EV_RETRY,
                5'd20, EV_SYSTEM_FAULT};
        foreach (seq[i]) send_event(seq[i]);
        wait_idle();
        // counter now sits above the new limit; RETRY must time out and keep it
        lim_img = 8'd1;
        commit_config(1'b1);
        send_event(EV_BROKER_DOWN);
        send_event(EV_RETRY);
        wait_idle();
    endtask

    // Random phases, each with a new random table and limit, written whole or in part, and its own idle level;
    // every fourth phase leans heavily on RETRY. The last phase runs flat out.
    task automatic test_random_phases();
        int ph;
        int n;
        int retry_bias;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            foreach (tbl_img[w]) tbl_img[w] = random_word();
            case ($urandom_range(0, 4))
                0:       lim_img = 8'd0;
                1:       lim_img = 8'hFF;
                2:       lim_img = 8'($urandom_range(0, 255));
                default: lim_img = 8'($urandom_range(1, 6));
            endcase
            commit_config(ph == 0 || $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (ph == RANDOM_PHASES - 1)
                idle_pct = 0;
            retry_bias = (ph % 4 == 3) ? 40 : 8;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_event(pick_event(retry_bias));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on m_ready, then the scoreboard
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Each accepted result transaction is matched against the oldest
    // expectation; values are sampled before this edge's updates land.
    always @(posedge aclk) begin
        conn_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, state %0d", m_conn_state));
            end else begin
                want = expected_results.pop_front();
                check_field("conn_state",    m_conn_state,    want.conn_state);
                check_field("retry_total",   m_retry_total,   want.retry_total);
                check_field("rule_matched",  m_rule_matched,  want.rule_matched);
                check_field("state_written", m_state_written, want.state_written);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_event_code <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;

        // model starts from the documented reset values
        mdl_limit   = 8'd3;
        mdl_mode    = ST_DISCONNECTED;
        mdl_retries = 8'd0;
        foreach (mdl_words[w]) mdl_words[w] = '0;
        lim_img = mdl_limit;
        tbl_img = mdl_words;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_fixed_events();
        test_table_rules();
        test_random_phases();

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
